[sv/tpbb_pkg.sv]
// ---------------------------------------------------------------------------
// Transformed point bounding box package
// Shared types, constants and the per-row affine transform function.
// ---------------------------------------------------------------------------
package tpbb_pkg;

  typedef logic signed [15:0] coord_t;

  // One coefficient row: c0 in the low bits, translation in the high bits.
  typedef struct packed {
    logic signed [15:0] t;
    logic signed [15:0] c2;
    logic signed [15:0] c1;
    logic signed [15:0] c0;
  } row_t;

  typedef enum logic [1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_idx_t;

  localparam coord_t EMPTY_MIN = 16'sh7fff;
  localparam coord_t EMPTY_MAX = 16'sh8000;

  localparam logic [63:0] ROW_X_RESET = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ROW_Y_RESET = 64'h0000_0000_0000_0100;
  localparam logic [63:0] ROW_Z_RESET = 64'h0000_0000_0001_0000;

  // Dot product in Q16.16, round half up to Q8.8, then saturate to 16 bits.
  function automatic coord_t apply_row(input row_t row, input coord_t x,
                                       input coord_t y, input coord_t z);
    logic signed [34:0] acc;
    logic signed [26:0] q;
    coord_t             res;
    acc = 35'(row.c0 * x) + 35'(row.c1 * y) + 35'(row.c2 * z)
        + 35'(35'(row.t) <<< 8) + 35'sd128;
    q = acc[34:8];
    if (q > 27'sd32767) begin
      res = EMPTY_MIN;
    end else if (q < -27'sd32768) begin
      res = EMPTY_MAX;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

endpackage

[sv/transformed_point_bounding_box_core.sv]
// ---------------------------------------------------------------------------
// Transformed point bounding box core
// Maps each vertex through a 3x4 affine matrix and tracks the axis aligned
// bounding box of the results; emits the box on the last vertex of a model.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  --------------------------------
//   vertex   in         in_valid / in_stall  vertex_x/y/z, last_vertex
//   box      out        out_valid/out_stall  box_min_x/y/z, box_max_x/y/z
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One vertex is taken every cycle while in_stall is low. A vertex is held in
// the input register, and the box of a last vertex is registered from there
// into the result register.
// Reset (rst, synchronous) restores the ROW_X/Y/Z_RESET coefficient rows and
// empties the running box; the result and input registers become empty.
// A stall on the box channel only holds up a vertex flagged last that would
// need the occupied result register; ordinary vertices keep folding in.
// ---------------------------------------------------------------------------
module transformed_point_bounding_box_core
  import tpbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  coord_t      vertex_x,
  input  coord_t      vertex_y,
  input  coord_t      vertex_z,
  input  logic        last_vertex,

  output logic        out_valid,
  input  logic        out_stall,
  output coord_t      box_min_x,
  output coord_t      box_min_y,
  output coord_t      box_min_z,
  output coord_t      box_max_x,
  output coord_t      box_max_y,
  output coord_t      box_max_z,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Coefficient rows.
  row_t row_x, row_y, row_z;

  // Input register.
  logic   s1_valid;
  coord_t s1_x, s1_y, s1_z;
  logic   s1_last;

  // Running box.
  coord_t run_min_x, run_min_y, run_min_z;
  coord_t run_max_x, run_max_y, run_max_z;

  coord_t tx, ty, tz;
  coord_t min_x_next, min_y_next, min_z_next;
  coord_t max_x_next, max_y_next, max_z_next;
  logic   s1_adv;
  logic   out_free;

  // The configuration port never stalls; writes must arrive only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= ROW_X_RESET;
      row_y <= ROW_Y_RESET;
      row_z <= ROW_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW_X: row_x <= cfg_data;
        CFG_ROW_Y: row_y <= cfg_data;
        CFG_ROW_Z: row_z <= cfg_data;
        default:   ;  // Unused index: write is dropped.
      endcase
    end
  end

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  // A plain vertex always folds in; a last vertex needs the result register.
  assign s1_adv   = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_x    <= vertex_x;
      s1_y    <= vertex_y;
      s1_z    <= vertex_z;
      s1_last <= last_vertex;
    end
  end

  // Transform: three independent rows of three 16x16 products each.
  assign tx = apply_row(row_x, s1_x, s1_y, s1_z);
  assign ty = apply_row(row_y, s1_x, s1_y, s1_z);
  assign tz = apply_row(row_z, s1_x, s1_y, s1_z);

  // Fold the transformed point into the running box.
  always_comb begin
    min_x_next = (tx < run_min_x) ? tx : run_min_x;
    min_y_next = (ty < run_min_y) ? ty : run_min_y;
    min_z_next = (tz < run_min_z) ? tz : run_min_z;
    max_x_next = (tx > run_max_x) ? tx : run_max_x;
    max_y_next = (ty > run_max_y) ? ty : run_max_y;
    max_z_next = (tz > run_max_z) ? tz : run_max_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min_x <= EMPTY_MIN;
      run_min_y <= EMPTY_MIN;
      run_min_z <= EMPTY_MIN;
      run_max_x <= EMPTY_MAX;
      run_max_y <= EMPTY_MAX;
      run_max_z <= EMPTY_MAX;
    end else if (s1_adv) begin
      if (s1_last) begin
        // The box leaves with this vertex; start the next model empty.
        run_min_x <= EMPTY_MIN;
        run_min_y <= EMPTY_MIN;
        run_min_z <= EMPTY_MIN;
        run_max_x <= EMPTY_MAX;
        run_max_y <= EMPTY_MAX;
        run_max_z <= EMPTY_MAX;
      end else begin
        run_min_x <= min_x_next;
        run_min_y <= min_y_next;
        run_min_z <= min_z_next;
        run_max_x <= max_x_next;
        run_max_y <= max_y_next;
        run_max_z <= max_z_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      box_min_x <= min_x_next;
      box_min_y <= min_y_next;
      box_min_z <= min_z_next;
      box_max_x <= max_x_next;
      box_max_y <= max_y_next;
      box_max_z <= max_z_next;
    end
  end

  // An emitted box always holds at least one point, so it is never inverted.
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y)
                  && (box_min_z <= box_max_z))
    else $error("emitted box has min above max");

  // After a last vertex leaves, the running box is empty again.
  a_box_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (run_min_x == EMPTY_MIN) && (run_max_x == EMPTY_MAX)
                            && (run_min_z == EMPTY_MIN) && (run_max_y == EMPTY_MAX))
    else $error("running box not cleared after emission");

  // The input side only stalls behind a last vertex blocked by a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_last && out_valid && out_stall)
    else $error("input stalled without a blocked last vertex");

  // A blocked last vertex stays in the input register.
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && out_valid && out_stall) |=> s1_valid && s1_last)
    else $error("blocked last vertex was lost");

endmodule
